FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked on every clock edge outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha256_front.sv
`default_nettype none
// drops empty items, queues the rest for the hash core
module sha256_front #(
  parameter int unsigned DEPTH = sha256_pkg::QueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sha256_pkg::in_item_t in_item,
  output logic                      q_valid,
  input  wire logic                 q_take,
  output sha256_pkg::in_item_t      q_item
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha256_pkg::in_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  assign in_stall = (cnt_r == (AW+1)'(DEPTH));
  assign push     = in_valid && !in_stall && (in_item.has_byte || in_item.last_byte);
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule
`default_nettype wire

FILE: rtl/core/sha256_core.sv
`default_nettype none
// byte packing, padding, round engine and digest output
module sha256_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_take,
  input  wire sha256_pkg::in_item_t q_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sha256_pkg::out_item_t     out_item
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_LEN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [60:0] cnt_r;
  logic [5:0]  rnd_r;
  logic        fin_r;   // block being compressed is the length block
  logic        pad2_r;  // padding spilled into a second block
  logic [1:0]  oi_r;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [1:0]  bi;
  logic [31:0] wcur, w15, w2, s0, s1, wnew, t1, t2, ch, maj, sg0, sg1;
  logic [31:0] a, b, c, d, e, f, g, h;

  logic q_item_last_pending;
  logic lastp_r;
  assign q_item_last_pending = lastp_r;

  assign pos = cnt_r[5:0];
  assign wi  = pos[5:2];
  assign bi  = pos[1:0];

  assign q_take = (st_r == ST_IDLE) && q_valid;

  assign a = v_r[0]; assign b = v_r[1]; assign c = v_r[2]; assign d = v_r[3];
  assign e = v_r[4]; assign f = v_r[5]; assign g = v_r[6]; assign h = v_r[7];

  always_comb begin
    w15  = w_r[1];
    w2   = w_r[14];
    s0   = sha256_pkg::ror32(w15, 7) ^ sha256_pkg::ror32(w15, 18) ^ (w15 >> 3);
    s1   = sha256_pkg::ror32(w2, 17) ^ sha256_pkg::ror32(w2, 19) ^ (w2 >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    wcur = w_r[0];
    sg1  = sha256_pkg::ror32(e, 6) ^ sha256_pkg::ror32(e, 11) ^ sha256_pkg::ror32(e, 25);
    sg0  = sha256_pkg::ror32(a, 2) ^ sha256_pkg::ror32(a, 13) ^ sha256_pkg::ror32(a, 22);
    ch   = (e & f) ^ (~e & g);
    maj  = (a & b) ^ (a & c) ^ (b & c);
    t1   = h + sg1 + ch + sha256_pkg::RoundK[rnd_r] + wcur;
    t2   = sg0 + maj;
  end

  assign out_valid = (st_r == ST_OUT);
  assign out_item.digest_word = {h_r[{oi_r, 1'b0}], h_r[{oi_r, 1'b1}]};
  assign out_item.word_index  = oi_r;
  assign out_item.last_word   = (oi_r == 2'd3);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_take) begin
          if (q_item.has_byte && pos == 6'd63) st_nxt = ST_RUN;
          else if (q_item.last_byte)           st_nxt = ST_PAD;
        end
      end
      ST_RUN:  if (rnd_r == 6'd63) st_nxt = ST_ADD;
      ST_ADD: begin
        if (fin_r)         st_nxt = ST_OUT;
        else if (pad2_r)   st_nxt = ST_LEN;
        else if (pos == 6'd0 && pad2_r == 1'b0 && st_r == ST_ADD && q_item_last_pending)
          st_nxt = ST_PAD;
        else               st_nxt = ST_IDLE;
      end
      ST_PAD:  st_nxt = ST_RUN;
      ST_LEN:  st_nxt = ST_RUN;
      ST_OUT:  if (!out_stall && oi_r == 2'd3) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      cnt_r   <= '0;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      pad2_r  <= 1'b0;
      oi_r    <= '0;
      lastp_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::InitHash[i];
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: begin
          if (q_take) begin
            if (q_item.has_byte) cnt_r <= cnt_r + 61'd1;
            lastp_r <= q_item.last_byte && q_item.has_byte && pos == 6'd63;
          end
        end
        ST_RUN:  rnd_r <= rnd_r + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          lastp_r <= 1'b0;
          if (fin_r) begin
            fin_r <= 1'b0;
          end else if (pad2_r) begin
            pad2_r <= 1'b0;
            fin_r  <= 1'b1;
          end
        end
        ST_PAD: begin
          if (pos >= 6'd56) pad2_r <= 1'b1;
          else              fin_r  <= 1'b1;
        end
        ST_LEN: ;
        ST_OUT: begin
          if (!out_stall) begin
            oi_r <= oi_r + 2'd1;
            if (oi_r == 2'd3) begin
              cnt_r <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::InitHash[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        if (q_take && q_item.has_byte)
          w_r[wi][(3-bi)*8 +: 8] <= q_item.data_byte;
        if (q_take && q_item.has_byte && pos == 6'd63)
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      ST_RUN: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        v_r[7] <= g; v_r[6] <= f; v_r[5] <= e; v_r[4] <= d + t1;
        v_r[3] <= c; v_r[2] <= b; v_r[1] <= a; v_r[0] <= t1 + t2;
      end
      ST_PAD: begin
        for (int i = 0; i < 16; i++) begin
          if (4'(i) > wi && (pos >= 6'd56 || i < 14)) w_r[i] <= '0;
        end
        for (int j = 0; j < 4; j++) begin
          if (2'(j) == bi)     w_r[wi][(3-j)*8 +: 8] <= sha256_pkg::PadByte;
          else if (2'(j) > bi) w_r[wi][(3-j)*8 +: 8] <= '0;
        end
        if (pos < 6'd56) begin
          w_r[14] <= {cnt_r[60:29]};
          w_r[15] <= {cnt_r[28:0], 3'b000};
        end
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      ST_LEN: begin
        for (int i = 0; i < 14; i++) w_r[i] <= '0;
        w_r[14] <= cnt_r[60:29];
        w_r[15] <= {cnt_r[28:0], 3'b000};
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/core/sha256_message_hash.sv
`default_nettype none
// sha-256 of a byte stream, one byte per item on the in_ channel
// in_item carries data_byte, has_byte and last_byte; an item with neither
// flag set is dropped. last_byte closes the message: the block pads it,
// runs one or two final compressions and sends four out_ items holding
// the 256-bit digest, most significant word first, last_word on the fourth.
// bytes are taken from the queue only while the core is idle; the 64th byte of a
// block starts the rounds and hash update, during which no byte is taken.
// after the last item the core pads, compresses and then shows the first digest
// word; a second final block is needed when under nine bytes remain for pad and length.
// a four-entry queue in front lets the sender keep going during rounds.
// out_stall holds the current digest word; the queue fills until stalled.
// reset empties the queue and restores the initial hash values.
module sha256_message_hash #(
  parameter int unsigned QUEUE_DEPTH = sha256_pkg::QueueDepth
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire sha256_pkg::in_item_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output sha256_pkg::out_item_t      out_item
);
  logic                 q_valid, q_take;
  sha256_pkg::in_item_t q_item;

  sha256_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_item, .q_valid, .q_take, .q_item
  );

  sha256_core u_core (
    .clk, .rst_n, .q_valid, .q_take, .q_item, .out_valid, .out_stall, .out_item
  );
endmodule
`default_nettype wire

FILE: rtl/core/sha256_checker.sv
`default_nettype none
`include "assert_macros.svh"
module sha256_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire sha256_pkg::out_item_t out_item
);
  logic out_take;
  logic out_end;
  assign out_take = out_valid && !out_stall;
  assign out_end  = out_take && out_item.last_word;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
  `ASSERT_NEXT(a_idx_step, clk, rst_n, out_take && !out_item.last_word, out_valid && out_item.word_index == $past(out_item.word_index) + 2'd1)
  `ASSERT_IMPL(a_last_idx, clk, rst_n, out_valid, out_item.last_word == (out_item.word_index == 2'd3))
  `ASSERT_NEXT(a_gap, clk, rst_n, out_end, !out_valid)
endmodule

bind sha256_message_hash sha256_checker u_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_item
);
`default_nettype wire

FILE: test/tb_sha256_message_hash.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_sha256_message_hash;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sha256_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sha256_pkg::out_item_t out_item;

  logic [31:0] hash_state [8];
  logic [31:0] msg_block [16];
  logic [60:0] byte_total;
  sha256_pkg::out_item_t digest_q [$];

  int unsigned error_count = 0;
  int unsigned item_count = 0;
  int unsigned digest_count = 0;
  int unsigned word_count = 0;
  int unsigned idle_cycles = 0;
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  int unsigned hold_cycles = 0;

  sha256_message_hash u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_clear();
    hash_state = sha256_pkg::InitHash;
    foreach (msg_block[i]) msg_block[i] = '0;
    byte_total = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, s0, s1, t1, t2;
    w = msg_block;
    v = hash_state;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        s0 = rotr(w[(r - 15) & 15], 7) ^ rotr(w[(r - 15) & 15], 18) ^ (w[(r - 15) & 15] >> 3);
        s1 = rotr(w[(r - 2) & 15], 17) ^ rotr(w[(r - 2) & 15], 19) ^ (w[(r - 2) & 15] >> 10);
        wt = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
        w[r & 15] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[r] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic store_byte(input int pos, input logic [7:0] b);
    msg_block[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = b;
  endtask

  task automatic hash_absorb(input sha256_pkg::in_item_t it);
    int pos;
    logic [63:0] bits;
    sha256_pkg::out_item_t o;
    if (it.has_byte) begin
      store_byte(int'(byte_total[5:0]), it.data_byte);
      byte_total = byte_total + 61'd1;
      if (byte_total[5:0] == 6'd0) compress_block();
    end
    if (!it.last_byte) return;
    pos = int'(byte_total[5:0]);
    store_byte(pos, sha256_pkg::PadByte);
    for (int i = pos + 1; i < 64; i++) store_byte(i, 8'h00);
    if (pos >= 56) begin
      compress_block();
      foreach (msg_block[i]) msg_block[i] = '0;
    end
    bits = {byte_total, 3'b000};
    msg_block[14] = bits[63:32];
    msg_block[15] = bits[31:0];
    compress_block();
    for (int i = 0; i < 4; i++) begin
      o.digest_word = {hash_state[2 * i], hash_state[2 * i + 1]};
      o.word_index = 2'(i);
      o.last_word = (i == 3);
      digest_q.push_back(o);
    end
    digest_count++;
    hash_clear();
  endtask

  task automatic send_item(input logic [7:0] b, input bit has, input bit last);
    sha256_pkg::in_item_t it;
    it.data_byte = b;
    it.has_byte = has;
    it.last_byte = last;
    while (sender_gaps && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_absorb(it);
    item_count++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(8'($urandom), 1'b1, i == len - 1);
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_idle();
    int unsigned n = 0;
    in_valid <= 1'b0;
    while (digest_q.size() != 0 && n < 200000) begin
      @(negedge clk);
      n++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= receiver_gaps && ($urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h", out_item.digest_word);
        error_count++;
      end else begin
        sha256_pkg::out_item_t e;
        e = digest_q.pop_front();
        if (out_item.digest_word !== e.digest_word) begin
          $error("digest_word expected %h actual %h", e.digest_word, out_item.digest_word);
          error_count++;
        end
        if (out_item.word_index !== e.word_index) begin
          $error("word_index expected %0d actual %0d", e.word_index, out_item.word_index);
          error_count++;
        end
        if (out_item.last_word !== e.last_word) begin
          $error("last_word expected %0d actual %0d", e.last_word, out_item.last_word);
          error_count++;
        end
      end
      word_count++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("sha256_message_hash: mismatch");
      $finish;
    end
  end

  task automatic test_edge_messages();
    send_item(8'h00, 1'b0, 1'b0);
    send_message(0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_padding_boundaries();
    int lens [3] = '{55, 56, 64};
    foreach (lens[i]) send_message(lens[i]);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    send_message(3);
    send_message(0);
    send_message(9);
    wait_idle();
  endtask

  task automatic test_random_messages();
    int sent = 0;
    int len;
    while (sent < 80) begin
      if ($urandom_range(9) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(70) : $urandom_range(12);
        if (sent >= 20 && sent < 50) begin
          sender_gaps = 1'b0;
          receiver_gaps = 1'b0;
        end else begin
          sender_gaps = 1'b1;
          receiver_gaps = 1'b1;
        end
        send_message(len);
        sent += (len == 0) ? 1 : len;
      end
    end
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    wait_idle();
  endtask

  initial begin
    hash_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_edge_messages();
    test_padding_boundaries();
    test_backpressure();
    test_random_messages();
    repeat (DrainCycles) @(negedge clk);
    $display("run covered %0d items and %0d digests (%0d words), including empty,",
             item_count, digest_count, word_count);
    $display("padding-boundary lengths, dropped items and a long output hold-off");
    if (error_count == 0 && digest_q.size() == 0) begin
      $display("sha256_message_hash: match");
    end else begin
      $display("sha256_message_hash: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
